// ===== rtl/twao_pkg.sv =====
// Shared types, constants and tables of the two-wheel arc odometry block.
// Depends on nothing; every other file of the block imports it.
package twao_pkg;

  // Field and datapath widths.
  localparam int DATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_NW = 64;      // divider numerator width
  localparam int DIV_DW = 40;      // divider denominator width
  localparam int MUL_W = 35;       // multiplier operand width
  localparam int ANG_W = 40;       // CORDIC input angle width, Q30 radians
  localparam int CS_W = 34;        // CORDIC x, y and result width
  localparam int CR_W = 35;        // CORDIC residual angle width
  localparam int PI_W = 33;        // width of the two-pi constant
  localparam int REDUCE_STEPS = 8; // 2*pi*2^7 covers the whole input range
  localparam int ATAN_DEPTH = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  // Q30 constants of the angle reduction and the CORDIC start vector.
  localparam logic [PI_W-1:0] Q30_TWO_PI = 33'd6746518852;
  localparam logic [PI_W-1:0] Q30_PI = 33'd3373259426;
  localparam logic [PI_W-1:0] Q30_HALF_PI = 33'd1686629713;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // Arctangent of 2^-i in Q30.
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_STEP = 2'd0;
  localparam logic [1:0] OP_SET_POSE = 2'd1;
  localparam logic [1:0] OP_TARE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET = 1'b1;

  // Set-pose mask bits and fault bits.
  localparam int MASK_X_BIT = 0;
  localparam int MASK_Y_BIT = 1;
  localparam int MASK_HEADING_BIT = 2;
  localparam int FAULT_DT_BIT = 0;
  localparam int FAULT_DEN_BIT = 1;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] left_distance;
    logic signed [DATA_W-1:0] right_distance;
    logic signed [DATA_W-1:0] left_angle;
    logic signed [DATA_W-1:0] right_angle;
    logic [DATA_W-1:0]        time_stamp;
    logic signed [DATA_W-1:0] new_x;
    logic signed [DATA_W-1:0] new_y;
    logic signed [DATA_W-1:0] new_heading;
    logic [2:0]               axis_mask;
  } step_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] heading;
    logic signed [DATA_W-1:0] left_rpm;
    logic signed [DATA_W-1:0] right_rpm;
    logic [1:0]               fault;
  } result_t;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_HDIV, ST_DH, ST_SIN1, ST_QDIV, ST_MUL1, ST_MUL2,
    ST_SIN2, ST_MULX, ST_MULY, ST_SPDL, ST_SPDR, ST_FIN
  } state_t;

  // Phases of the CORDIC unit.
  typedef enum logic [2:0] {
    CP_IDLE, CP_REDUCE, CP_WRAP, CP_FOLD, CP_ROTATE
  } cphase_t;

endpackage

// ===== rtl/twao_ifs.sv =====
// Handshake interfaces of the odometry block: step input, result output, config writes.
// Depends on twao_pkg for the payload types and widths.
interface twao_step_if import twao_pkg::*; ();
  logic  valid;
  logic  ready;
  step_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twao_result_if import twao_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twao_cfg_if import twao_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_W-1:0]     index;
  logic signed [DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/twao_div.sv =====
// Iterative signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on twao_pkg for the default widths.
module twao_div import twao_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] qr;
  logic [DW-1:0] rem;
  logic [DW-1:0] ud;
  logic          negq;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          take;
  logic [NW-1:0] un;
  logic [DW-1:0] udn;

  // Operand magnitudes.
  assign un = num[NW-1] ? (~$unsigned(num) + 1'b1) : $unsigned(num);
  assign udn = den[DW-1] ? (~$unsigned(den) + 1'b1) : $unsigned(den);

  // Restoring step: shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem, qr[NW-1]};
  assign diff = rem_sh - {1'b0, ud};
  assign take = !diff[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        qr <= un;
        rem <= '0;
        ud <= udn;
        negq <= num[NW-1] ^ den[DW-1];
      end else if (busy) begin
        qr <= {qr[NW-2:0], take};
        rem <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign of the quotient follows the operand signs.
  assign quo = $signed(negq ? (~qr + 1'b1) : qr);
endmodule

// ===== rtl/twao_mul.sv =====
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on twao_pkg for the default operand width.
module twao_mul import twao_pkg::*; #(
  parameter int W = MUL_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic                  done,
  output logic signed [2*W-1:0] p
);
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ua;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic          neg;
  logic [W:0]    sum;
  logic [2*W-1:0] mag;

  // Add the multiplicand when the low multiplier bit is set.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, ua} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
        ua <= a[W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
        lo <= b[W-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
        hi <= '0;
        neg <= a[W-1] ^ b[W-1];
      end else if (busy) begin
        hi <= sum[W:1];
        lo <= {sum[0], lo[W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag = {hi, lo};
  assign p = $signed(neg ? (~mag + 1'b1) : mag);
endmodule

// ===== rtl/twao_cordic.sv =====
// Iterative CORDIC sine and cosine in Q30 with range reduction by shifted two-pi subtraction.
// Depends on twao_pkg for widths, constants, the arctangent table and the phase type.
module twao_cordic import twao_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    done,
  output logic signed [CS_W-1:0]  sin_o,
  output logic signed [CS_W-1:0]  cos_o
);
  localparam int RK_W = $clog2(REDUCE_STEPS);
  localparam int IT_W = $clog2(ATAN_DEPTH);
  localparam logic signed [CR_W-1:0] R_PI = CR_W'(Q30_PI);
  localparam logic signed [CR_W-1:0] R_HALF = CR_W'(Q30_HALF_PI);
  localparam logic signed [CS_W-1:0] X_INIT = CS_W'(CORDIC_GAIN);

  cphase_t                phase;
  cphase_t                phase_next;
  logic [RK_W-1:0]        kidx;
  logic [IT_W-1:0]        it;
  logic [ANG_W-1:0]       mag;
  logic                   negin;
  logic                   negout;
  logic signed [CR_W-1:0] r;
  logic signed [CS_W-1:0] x;
  logic signed [CS_W-1:0] y;
  logic [ANG_W:0]         tp;
  logic [ANG_W:0]         sub;
  logic [PI_W-1:0]        w0;
  logic signed [CR_W-1:0] wrap;
  logic signed [CS_W-1:0] xs;
  logic signed [CS_W-1:0] ys;
  logic signed [CR_W-1:0] at;

  // Reduction: subtract two-pi times a falling power of two.
  assign tp = (ANG_W + 1)'(Q30_TWO_PI) << kidx;
  assign sub = {1'b0, mag} - tp;

  // Floor modulo for negative input, then move into (-pi, pi].
  assign w0 = (negin && (mag != '0)) ? (Q30_TWO_PI - mag[PI_W-1:0]) : mag[PI_W-1:0];
  assign wrap = (w0 > Q30_PI) ? (CR_W'(w0) - CR_W'(Q30_TWO_PI)) : CR_W'(w0);

  // Rotation terms.
  assign xs = x >>> it;
  assign ys = y >>> it;
  assign at = CR_W'(ATAN_TAB[it]);

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      CP_IDLE:   if (start) phase_next = CP_REDUCE;
      CP_REDUCE: if (kidx == '0) phase_next = CP_WRAP;
      CP_WRAP:   phase_next = CP_FOLD;
      CP_FOLD:   phase_next = CP_ROTATE;
      CP_ROTATE: if (it == IT_W'(STEPS - 1)) phase_next = CP_IDLE;
      default:   phase_next = CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= CP_IDLE;
      done <= 1'b0;
    end else begin
      phase <= phase_next;
      done <= (phase == CP_ROTATE) && (it == IT_W'(STEPS - 1));
    end
  end

  // Datapath of each phase.
  always_ff @(posedge clk) begin
    case (phase)
      CP_IDLE: begin
        if (start) begin
          mag <= angle[ANG_W-1] ? (~$unsigned(angle) + 1'b1) : $unsigned(angle);
          negin <= angle[ANG_W-1];
          kidx <= RK_W'(REDUCE_STEPS - 1);
        end
      end
      CP_REDUCE: begin
        if (!sub[ANG_W]) mag <= sub[ANG_W-1:0];
        kidx <= kidx - 1'b1;
      end
      CP_WRAP: r <= wrap;
      CP_FOLD: begin
        if (r > R_HALF) begin
          r <= R_PI - r;
          negout <= 1'b1;
        end else if (r < -R_HALF) begin
          r <= -R_PI - r;
          negout <= 1'b1;
        end else begin
          negout <= 1'b0;
        end
        x <= X_INIT;
        y <= '0;
        it <= '0;
      end
      CP_ROTATE: begin
        if (!r[CR_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          r <= r - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          r <= r + at;
        end
        it <= it + 1'b1;
      end
      default: ;
    endcase
  end

  assign sin_o = y;
  assign cos_o = negout ? -x : x;
endmodule

// ===== rtl/two_wheel_arc_odometry.sv =====
// Top level of the two-wheel arc odometry block: sequencer, pose state and result register.
// Depends on twao_pkg, the interfaces, twao_div, twao_mul and twao_cordic.
//
// Use: each transaction on the step channel carries an opcode. An odometry step takes
// both wheels' cumulative distances and angles and a time stamp and updates the pose
// and the wheel speeds; set pose writes the axes picked by the mask; tare zeroes the
// previous wheel readings. Every transaction yields one result on the result channel
// with the pose, the speeds and a fault code. The config channel writes the two wheel
// offsets and is always ready; write it only while the block is idle.
// Flow: the block takes one transaction at a time. Set pose, tare and the unused code
// go from the idle state straight to the final state and the result register. An
// odometry step runs on one shared divider (one quotient bit per cycle), one shift-add
// multiplier and one CORDIC unit, used in turn; a fault skips the pose or the speed
// part. The divider, used up to four times a step, takes most of a step's run time.
// A result register sits on the output: the next step is taken while a result waits,
// and a finished result waits in the sequencer until the register is free.
// Reset (synchronous) clears pose, speeds and previous readings and loads the offsets.
module two_wheel_arc_odometry import twao_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic            clk,
  input logic            rst,
  twao_step_if.sink      step,
  twao_result_if.source  result,
  twao_cfg_if.sink       cfg
);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  // Architectural state.
  logic signed [DATA_W-1:0] left_offset;
  logic signed [DATA_W-1:0] right_offset;
  logic signed [DATA_W-1:0] last_left_distance;
  logic signed [DATA_W-1:0] last_right_distance;
  logic signed [DATA_W-1:0] last_left_angle;
  logic signed [DATA_W-1:0] last_right_angle;
  logic [DATA_W-1:0]        last_time;
  logic signed [DATA_W-1:0] world_x;
  logic signed [DATA_W-1:0] world_y;
  logic signed [DATA_W-1:0] world_heading;
  logic signed [DATA_W-1:0] speed_left;
  logic signed [DATA_W-1:0] speed_right;

  // Sequencer and output register.
  state_t  st;
  state_t  st_next;
  logic    launched;
  logic    launched_next;
  logic    out_valid;
  result_t res;
  logic    step_acc;
  logic    fin_go;

  // Work registers of one step.
  step_t              cap;
  logic signed [32:0] dl;
  logic signed [33:0] dd;
  logic signed [32:0] dla;
  logic signed [32:0] dra;
  logic signed [32:0] den;
  logic [34:0]        dt6;
  logic [1:0]         fault;
  logic signed [31:0] nh;
  logic signed [32:0] dh;
  logic signed [34:0] k;
  logic signed [32:0] q;
  logic signed [39:0] t1;
  logic signed [33:0] chord;
  logic signed [CS_W-1:0] s2;
  logic signed [CS_W-1:0] c2;

  // Shared unit ports.
  logic                     div_start;
  logic signed [DIV_NW-1:0] div_num;
  logic signed [DIV_DW-1:0] div_den;
  logic                     div_done;
  logic signed [DIV_NW-1:0] div_quo;
  logic                     mul_start;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic                     mul_done;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [39:0]       mul_sh;
  logic                     cs_start;
  logic signed [ANG_W-1:0]  cs_angle;
  logic                     cs_done;
  logic signed [CS_W-1:0]   cs_sin;
  logic signed [CS_W-1:0]   cs_cos;

  // Combinational values of the datapath.
  logic signed [32:0] dl_c;
  logic signed [32:0] dr_c;
  logic signed [32:0] dla_c;
  logic signed [32:0] dra_c;
  logic signed [32:0] den_c;
  logic [31:0]        dt_c;
  logic signed [64:0] hsum;
  logic signed [32:0] dh_c;
  logic signed [32:0] hs_c;
  logic signed [32:0] q_c;
  logic signed [40:0] csum;
  logic signed [33:0] chord_c;
  logic signed [64:0] xsum;
  logic signed [64:0] ysum;

  assign step_acc = step.valid && step.ready;
  assign fin_go = !out_valid || result.ready;

  // Deltas against the previous readings.
  assign dl_c = {cap.left_distance[31], cap.left_distance}
              - {last_left_distance[31], last_left_distance};
  assign dr_c = {cap.right_distance[31], cap.right_distance}
              - {last_right_distance[31], last_right_distance};
  assign dla_c = {cap.left_angle[31], cap.left_angle} - {last_left_angle[31], last_left_angle};
  assign dra_c = {cap.right_angle[31], cap.right_angle}
               - {last_right_angle[31], last_right_angle};
  assign den_c = {left_offset[31], left_offset} - {right_offset[31], right_offset};
  assign dt_c = cap.time_stamp - last_time;

  // Heading update, change and mean heading.
  assign hsum = {{33{world_heading[31]}}, world_heading} + {div_quo[DIV_NW-1], div_quo};
  assign dh_c = {nh[31], nh} - {world_heading[31], world_heading};
  assign hs_c = {world_heading[31], world_heading} + {nh[31], nh};

  // Chord scale clamp and chord clamp.
  assign q_c = (div_quo > 64'sd2147483648) ? 33'sd2147483648 :
               (div_quo < -64'sd2147483648) ? -33'sd2147483648 : div_quo[32:0];
  assign mul_sh = mul_p[2*MUL_W-1:30];
  assign csum = {t1[39], t1} + {mul_sh[39], mul_sh};
  assign chord_c = (csum > 41'sd4294967296) ? 34'sd4294967296 :
                   (csum < -41'sd4294967296) ? -34'sd4294967296 : csum[33:0];

  // Position updates.
  assign xsum = {{33{world_x[31]}}, world_x} + {{25{mul_sh[39]}}, mul_sh};
  assign ysum = {{33{world_y[31]}}, world_y} + {{25{mul_sh[39]}}, mul_sh};

  // Operand selection for the shared units.
  always_comb begin
    div_num = '0;
    div_den = '0;
    mul_a = '0;
    mul_b = '0;
    cs_angle = '0;
    case (st)
      ST_HDIV: begin
        div_num = {{6{dd[33]}}, dd, 24'b0};
        div_den = {{7{den[32]}}, den};
      end
      ST_QDIV: begin
        div_num = {{5{k[34]}}, k, 24'b0};
        div_den = {{7{dh[32]}}, dh};
      end
      ST_SPDL: begin
        div_num = {{9{dla[32]}}, dla, 22'b0};
        div_den = {5'b0, dt6};
      end
      ST_SPDR: begin
        div_num = {{9{dra[32]}}, dra, 22'b0};
        div_den = {5'b0, dt6};
      end
      ST_MUL1: begin
        mul_a = {{2{dl[32]}}, dl};
        mul_b = {{2{q[32]}}, q};
      end
      ST_MUL2: begin
        mul_a = k;
        mul_b = {{3{left_offset[31]}}, left_offset};
      end
      ST_MULX: begin
        mul_a = {chord[33], chord};
        mul_b = {s2[CS_W-1], s2};
      end
      ST_MULY: begin
        mul_a = {chord[33], chord};
        mul_b = {c2[CS_W-1], c2};
      end
      ST_SIN1: cs_angle = {{2{dh[32]}}, dh, 5'b0};
      ST_SIN2: cs_angle = {{2{hs_c[32]}}, hs_c, 5'b0};
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (step_acc) st_next = (step.payload.opcode == OP_STEP) ? ST_PREP : ST_FIN;
      ST_PREP: begin
        if (den_c != '0) st_next = ST_HDIV;
        else st_next = (dt_c == '0) ? ST_FIN : ST_SPDL;
      end
      ST_HDIV: if (div_done) st_next = ST_DH;
      ST_DH:   st_next = (dh_c == '0) ? ST_SIN2 : ST_SIN1;
      ST_SIN1: if (cs_done) st_next = ST_QDIV;
      ST_QDIV: if (div_done) st_next = ST_MUL1;
      ST_MUL1: if (mul_done) st_next = ST_MUL2;
      ST_MUL2: if (mul_done) st_next = ST_SIN2;
      ST_SIN2: if (cs_done) st_next = ST_MULX;
      ST_MULX: if (mul_done) st_next = ST_MULY;
      ST_MULY: if (mul_done) st_next = fault[FAULT_DT_BIT] ? ST_FIN : ST_SPDL;
      ST_SPDL: if (div_done) st_next = ST_SPDR;
      ST_SPDR: if (div_done) st_next = ST_FIN;
      ST_FIN:  if (fin_go) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts and the step channel's ready.
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    cs_start = 1'b0;
    unique case (st)
      ST_HDIV, ST_QDIV, ST_SPDL, ST_SPDR: div_start = !launched;
      ST_MUL1, ST_MUL2, ST_MULX, ST_MULY: mul_start = !launched;
      ST_SIN1, ST_SIN2:                   cs_start = !launched;
      default: ;
    endcase
    launched_next = launched;
    if (div_start || mul_start || cs_start) launched_next = 1'b1;
    if (div_done || mul_done || cs_done) launched_next = 1'b0;
  end

  assign step.ready = (st == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      st <= st_next;
      launched <= launched_next;
    end
  end

  // Configuration and pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_offset <= -32'sd327680;
      right_offset <= 32'sd327680;
      last_left_distance <= '0;
      last_right_distance <= '0;
      last_left_angle <= '0;
      last_right_angle <= '0;
      last_time <= '0;
      world_x <= '0;
      world_y <= '0;
      world_heading <= '0;
      speed_left <= '0;
      speed_right <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_LEFT_OFFSET) left_offset <= cfg.data;
        else right_offset <= cfg.data;
      end
      case (st)
        ST_IDLE: begin
          if (step_acc) begin
            unique case (step.payload.opcode)
              OP_SET_POSE: begin
                if (step.payload.axis_mask[MASK_X_BIT]) world_x <= step.payload.new_x;
                if (step.payload.axis_mask[MASK_Y_BIT]) world_y <= step.payload.new_y;
                if (step.payload.axis_mask[MASK_HEADING_BIT]) begin
                  world_heading <= step.payload.new_heading;
                end
              end
              OP_TARE: begin
                last_left_distance <= '0;
                last_right_distance <= '0;
                last_left_angle <= '0;
                last_right_angle <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          last_left_distance <= cap.left_distance;
          last_right_distance <= cap.right_distance;
          last_left_angle <= cap.left_angle;
          last_right_angle <= cap.right_angle;
          last_time <= cap.time_stamp;
        end
        ST_MULX: if (mul_done) world_x <= sat32(xsum);
        ST_MULY: begin
          if (mul_done) begin
            world_y <= sat32(ysum);
            world_heading <= nh;
          end
        end
        ST_SPDL: if (div_done) speed_left <= sat32({div_quo[DIV_NW-1], div_quo});
        ST_SPDR: if (div_done) speed_right <= sat32({div_quo[DIV_NW-1], div_quo});
        default: ;
      endcase
    end
  end

  // Work registers of the running step.
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (step_acc) begin
          cap <= step.payload;
          fault <= 2'b00;
        end
      end
      ST_PREP: begin
        dl <= dl_c;
        dd <= {dr_c[32], dr_c} - {dl_c[32], dl_c};
        dla <= dla_c;
        dra <= dra_c;
        den <= den_c;
        dt6 <= {1'b0, dt_c, 2'b0} + {2'b0, dt_c, 1'b0};
        fault[FAULT_DEN_BIT] <= (den_c == '0);
        fault[FAULT_DT_BIT] <= (dt_c == '0);
      end
      ST_HDIV: if (div_done) nh <= sat32(hsum);
      ST_DH: begin
        dh <= dh_c;
        if (dh_c == '0) chord <= {dl[32], dl};
      end
      ST_SIN1: if (cs_done) k <= {cs_sin, 1'b0};
      ST_QDIV: if (div_done) q <= q_c;
      ST_MUL1: if (mul_done) t1 <= mul_sh;
      ST_MUL2: if (mul_done) chord <= chord_c;
      ST_SIN2: begin
        if (cs_done) begin
          s2 <= cs_sin;
          c2 <= cs_cos;
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (st == ST_FIN && fin_go) out_valid <= 1'b1;
      else if (result.valid && result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_FIN && fin_go) begin
      res.pos_x <= world_x;
      res.pos_y <= world_y;
      res.heading <= world_heading;
      res.left_rpm <= speed_left;
      res.right_rpm <= speed_right;
      res.fault <= fault;
    end
  end

  assign result.valid = out_valid;
  assign result.payload = res;

  twao_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  twao_mul #(.W(MUL_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  twao_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .angle(cs_angle),
    .done(cs_done), .sin_o(cs_sin), .cos_o(cs_cos)
  );
endmodule
